>>> hdl/ilf_pkg.sv
// ilf_pkg: shared types and constants of the indexed list with free list
// transfer payloads, action and status codes, link memory request group
// depends on nothing
package ilf_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LINK_W   = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    // link value that marks the end of a list
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);
    localparam logic [LINK_W-1:0] CAP_COUNT = LINK_W'(CAPACITY);

    localparam logic [2:0] ACT_APPEND = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_READ   = 3'd2;
    localparam logic [2:0] ACT_WRITE  = 3'd3;
    localparam logic [2:0] ACT_CLEAR  = 3'd4;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]              action;
        logic [IDX_W-1:0]        entry_index;
        logic [IDX_W-1:0]        prev_index;
        logic                    prev_present;
        logic signed [DATA_W-1:0] data_in;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]        result_index;
        logic                    result_null;
        logic signed [DATA_W-1:0] data_out;
        status_t                 status;
    } rsp_t;

    typedef struct packed {
        logic              re;
        logic [IDX_W-1:0]  raddr;
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [LINK_W-1:0] wdata;
    } link_req_t;

endpackage

>>> hdl/ilf_stream_if.sv
// ilf_stream_if: valid/ready channel carrying one payload per transfer
// payload type is a parameter, normally ilf_pkg::req_t or ilf_pkg::rsp_t
interface ilf_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/ilf_ram.sv
// ilf_ram: simple dual port synchronous memory, one read and one write port
// registered read data, read returns the old word on a same-address write
// depends on nothing
module ilf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

>>> hdl/ilf_ctrl.sv
// ilf_ctrl: sequencer and list registers of the indexed list
// issues link and value memory accesses in the issue state, finishes each action in the finish state that follows
// depends on ilf_pkg
module ilf_ctrl import ilf_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    input  req_t                   req_payload,
    output logic                   req_ready,
    output logic                   res_valid,
    input  logic                   res_ready,
    output rsp_t                   res,
    output link_req_t              link_req,
    input  logic [LINK_W-1:0]      link_rdata,
    output logic                   val_re,
    output logic                   val_we,
    output logic [IDX_W-1:0]       val_addr,
    output logic [VALUE_WIDTH-1:0] val_wdata,
    input  logic [VALUE_WIDTH-1:0] val_rdata
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_ISSUE  = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] tail_reg, tail_next;
    logic [LINK_W-1:0] free_head_reg, free_head_next;
    logic [LINK_W-1:0] free_count_reg, free_count_next;
    logic [LINK_W-1:0] used_reg, used_next;
    // per-action context carried from issue to finish
    status_t           st_reg, st_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic              take_free_reg, take_free_next;
    logic              tail_slot_reg, tail_slot_next;
    logic              head_match_reg, head_match_next;

    logic [LINK_W-1:0] idx_ext;
    logic [LINK_W-1:0] prev_ext;
    logic              take_free;
    logic [IDX_W-1:0]  slot;
    logic              full;
    logic              idx_bad;
    logic              prev_bad;
    logic              tail_valid;
    logic              fire;

    assign idx_ext    = LINK_W'(req_reg.entry_index);
    assign prev_ext   = LINK_W'(req_reg.prev_index);
    assign take_free  = (free_count_reg != '0) && (free_head_reg < NULL_LINK);
    assign slot       = take_free ? free_head_reg[IDX_W-1:0] : used_reg[IDX_W-1:0];
    assign full       = !take_free && (used_reg >= CAP_COUNT);
    assign idx_bad    = idx_ext >= used_reg;
    assign prev_bad   = req_reg.prev_present && (prev_ext >= used_reg);
    assign tail_valid = tail_reg < NULL_LINK;
    assign res_valid  = (state_reg == S_FINISH);
    assign fire       = res_valid && res_ready;

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        used_next       = used_reg;
        st_next         = st_reg;
        slot_next       = slot_reg;
        take_free_next  = take_free_reg;
        tail_slot_next  = tail_slot_reg;
        head_match_next = head_match_reg;
        link_req        = '0;
        val_re          = 1'b0;
        val_we          = 1'b0;
        val_addr        = req_reg.entry_index;
        val_wdata       = VALUE_WIDTH'(req_reg.data_in);
        res             = '0;
        res.status      = st_reg;
        req_ready       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
            end
            S_ISSUE:
            begin
                st_next    = ST_OK;
                state_next = S_FINISH;
                unique case (req_reg.action)
                    ACT_APPEND:
                    begin
                        if (full)
                        begin
                            st_next = ST_FULL;
                        end
                        else
                        begin
                            if (take_free)
                            begin
                                link_req.re     = 1'b1;
                                link_req.raddr  = free_head_reg[IDX_W-1:0];
                                free_count_next = free_count_reg - LINK_W'(1);
                            end
                            else
                            begin
                                used_next = used_reg + LINK_W'(1);
                            end
                            val_we   = 1'b1;
                            val_addr = slot;
                            if (tail_valid)
                            begin
                                link_req.we    = 1'b1;
                                link_req.waddr = tail_reg[IDX_W-1:0];
                                link_req.wdata = LINK_W'(slot);
                            end
                            else
                            begin
                                head_next = LINK_W'(slot);
                            end
                            tail_next      = LINK_W'(slot);
                            slot_next      = slot;
                            take_free_next = take_free;
                            // tail already linked to itself, finish must not overwrite
                            tail_slot_next = tail_valid && (tail_reg[IDX_W-1:0] == slot);
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (idx_bad || prev_bad)
                        begin
                            st_next = ST_BAD;
                        end
                        else
                        begin
                            // read the old next link while pushing the entry on the free list
                            link_req.re    = 1'b1;
                            link_req.raddr = req_reg.entry_index;
                            link_req.we    = 1'b1;
                            link_req.waddr = req_reg.entry_index;
                            link_req.wdata = free_head_reg;
                            free_head_next = idx_ext;
                            if (free_count_reg < CAP_COUNT)
                            begin
                                free_count_next = free_count_reg + LINK_W'(1);
                            end
                            if (tail_reg == idx_ext)
                            begin
                                tail_next = req_reg.prev_present ? prev_ext : NULL_LINK;
                            end
                            head_match_next = (head_reg == idx_ext);
                        end
                    end
                    ACT_READ:
                    begin
                        if (idx_bad)
                        begin
                            st_next = ST_BAD;
                        end
                        else
                        begin
                            link_req.re    = 1'b1;
                            link_req.raddr = req_reg.entry_index;
                            val_re         = 1'b1;
                        end
                    end
                    ACT_WRITE:
                    begin
                        if (idx_bad)
                        begin
                            st_next = ST_BAD;
                        end
                        else
                        begin
                            val_we = 1'b1;
                        end
                    end
                    ACT_CLEAR:
                    begin
                        head_next       = NULL_LINK;
                        tail_next       = NULL_LINK;
                        free_head_next  = NULL_LINK;
                        free_count_next = '0;
                        used_next       = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FINISH:
            begin
                if (st_reg == ST_OK)
                begin
                    unique case (req_reg.action)
                        ACT_APPEND:
                        begin
                            res.result_index = slot_reg;
                            if (fire)
                            begin
                                if (take_free_reg)
                                begin
                                    free_head_next = link_rdata;
                                end
                                if (!tail_slot_reg)
                                begin
                                    link_req.we    = 1'b1;
                                    link_req.waddr = slot_reg;
                                    link_req.wdata = NULL_LINK;
                                end
                            end
                        end
                        ACT_REMOVE:
                        begin
                            res.result_null  = (link_rdata >= NULL_LINK);
                            res.result_index = res.result_null ? '0 : link_rdata[IDX_W-1:0];
                            if (fire)
                            begin
                                if (head_match_reg)
                                begin
                                    head_next = link_rdata;
                                end
                                // a predecessor equal to the entry keeps the free link
                                if (req_reg.prev_present &&
                                    (req_reg.prev_index != req_reg.entry_index))
                                begin
                                    link_req.we    = 1'b1;
                                    link_req.waddr = req_reg.prev_index;
                                    link_req.wdata = link_rdata;
                                end
                            end
                        end
                        ACT_READ:
                        begin
                            res.result_null  = (link_rdata >= NULL_LINK);
                            res.result_index = res.result_null ? '0 : link_rdata[IDX_W-1:0];
                            res.data_out     = DATA_W'(signed'(val_rdata));
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (fire)
                begin
                    req_ready  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (req_valid && req_ready)
        begin
            req_next   = req_payload;
            state_next = S_ISSUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= NULL_LINK;
            tail_reg       <= NULL_LINK;
            free_head_reg  <= NULL_LINK;
            free_count_reg <= '0;
            used_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            used_reg       <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        st_reg         <= st_next;
        slot_reg       <= slot_next;
        take_free_reg  <= take_free_next;
        tail_slot_reg  <= tail_slot_next;
        head_match_reg <= head_match_next;
    end

endmodule

>>> hdl/indexed_list_with_free_list.sv
// indexed_list_with_free_list: one singly linked list held by index in a
// fixed store of 64 entries, with a free list of removed entries.
// Channels: req (sink) carries action, entry_index, prev_index, prev_present
// and data_in; rsp (source) carries result_index, result_null, data_out and
// status, exactly one rsp transfer for every req transfer, in order.
// Each action passes through an issue state and a finish state; a new req is
// taken in the idle state or when the finish state hands its result over.
// The link memory reads the next link in the issue state for use in the finish state.
// The rsp transfer is offered from the output register, which is loaded when
// the finish state hands its result over.
// The rsp side has an output register: a new req is taken while a result
// waits there; when it is still full at the finish cycle, the block holds
// that result and takes no more req until the receiver drains the register.
// Reset clears the list head, tail, free list and high-water mark at once;
// the link and value memories are not cleared and need no sweep, since an
// entry is only read after an append has written it.
// depends on ilf_pkg, ilf_stream_if, ilf_ram, ilf_ctrl
module indexed_list_with_free_list import ilf_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    ilf_stream_if.sink   req,
    ilf_stream_if.source rsp
);

    link_req_t              link_req;
    logic [LINK_W-1:0]      link_rdata;
    logic                   val_re;
    logic                   val_we;
    logic [IDX_W-1:0]       val_addr;
    logic [VALUE_WIDTH-1:0] val_wdata;
    logic [VALUE_WIDTH-1:0] val_rdata;
    logic                   res_valid;
    logic                   res_ready;
    rsp_t                   res;
    logic                   out_valid_reg, out_valid_next;
    rsp_t                   out_data_reg;

    ilf_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_payload (req.payload),
        .req_ready   (req.ready),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .link_req    (link_req),
        .link_rdata  (link_rdata),
        .val_re      (val_re),
        .val_we      (val_we),
        .val_addr    (val_addr),
        .val_wdata   (val_wdata),
        .val_rdata   (val_rdata)
    );

    ilf_ram #(
        .WIDTH (LINK_W),
        .DEPTH (CAPACITY)
    ) u_link_mem (
        .clk   (clk),
        .re    (link_req.re),
        .raddr (link_req.raddr),
        .rdata (link_rdata),
        .we    (link_req.we),
        .waddr (link_req.waddr),
        .wdata (link_req.wdata)
    );

    ilf_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (CAPACITY)
    ) u_value_mem (
        .clk   (clk),
        .re    (val_re),
        .raddr (val_addr),
        .rdata (val_rdata),
        .we    (val_we),
        .waddr (val_addr),
        .wdata (val_wdata)
    );

    // output register, refilled in the same cycle it is drained
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        priority if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_data_reg;

    // the issue cycle after a req transfer never offers a result
    a_no_result_in_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !res_valid)
        else $error("result offered in the issue cycle");

    // a held result blocks new requests
    a_hold_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |-> !req.ready)
        else $error("request taken while a result is held");

    // a handed-over result lands in the output register
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> rsp.valid)
        else $error("handed-over result lost");

    // every written link is an entry index or the end marker
    a_link_range: assert property (@(posedge clk) disable iff (!rst_n)
        link_req.we |-> (link_req.wdata <= NULL_LINK))
        else $error("link write out of range");

endmodule
